>>> hdl/brf_pkg.sv
// shared constants, command type and index helpers for the byte ring fifo
`default_nettype none
package brf_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int LW     = AW + 1;
  localparam int MODE_W = 3;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] OP_PUSH       = 3'd0;
  localparam logic [MODE_W-1:0] OP_PUSH_OW    = 3'd1;
  localparam logic [MODE_W-1:0] OP_POP        = 3'd2;
  localparam logic [MODE_W-1:0] OP_PEEK       = 3'd3;
  localparam logic [MODE_W-1:0] OP_DROP       = 3'd4;
  localparam logic [MODE_W-1:0] OP_PEEK_RANGE = 3'd5;
  localparam logic [MODE_W-1:0] OP_POP_RANGE  = 3'd6;
  localparam logic [MODE_W-1:0] OP_NOP        = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd3;

  localparam int CQ_AW    = 1;
  localparam int CQ_DEPTH = 2 ** CQ_AW;

  typedef struct packed {
    logic [MODE_W-1:0] op;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              cnt_zero;
  } cmd_t;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    logic [AW-1:0] r;
    if (idx == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + AW'(1);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] idx,
                                             input logic [AW-1:0] n);
    logic [AW:0] s;
    s = {1'b0, idx} + {1'b0, n};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/brf_front.sv
// front end: accepts items, decodes the operation and queues commands
`default_nettype none
module brf_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [brf_pkg::MODE_W-1:0] mode,
  input  wire logic [brf_pkg::DATA_W-1:0] data_in,
  input  wire logic [brf_pkg::CNT_W-1:0]  item_count,
  output logic                            cmd_valid,
  output brf_pkg::cmd_t                   cmd,
  input  wire logic                       cmd_take
);
  import brf_pkg::*;

  cmd_t             q [CQ_DEPTH];
  logic [CQ_AW-1:0] wptr;
  logic [CQ_AW-1:0] rptr;
  logic [CQ_AW:0]   fill;
  cmd_t             dec;
  logic             push;
  logic             pop;

  always_comb begin
    dec.data     = data_in;
    dec.count    = item_count;
    dec.cnt_zero = (item_count == '0);
    unique case (mode)
      OP_PUSH:       dec.op = OP_PUSH;
      OP_PUSH_OW:    dec.op = OP_PUSH_OW;
      OP_POP:        dec.op = OP_POP;
      OP_PEEK:       dec.op = OP_PEEK;
      OP_DROP:       dec.op = OP_DROP;
      OP_PEEK_RANGE: begin
        dec.op       = OP_PEEK_RANGE;
      end
      OP_POP_RANGE: begin
        dec.op       = OP_POP_RANGE;
      end
      default:       dec.op = OP_NOP;
    endcase
  end

  assign in_stall  = (fill == (CQ_AW+1)'(CQ_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rptr];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + CQ_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + CQ_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (CQ_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (CQ_AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/brf_back.sv
// back end: byte store, ring pointers, range sequencer and result register
`default_nettype none
module brf_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  input  wire brf_pkg::cmd_t               cmd,
  output logic                             cmd_take,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [brf_pkg::STAT_W-1:0]       status,
  output logic [brf_pkg::DATA_W-1:0]       data_out,
  output logic [brf_pkg::CNT_W-1:0]        level,
  output logic                             last
);
  import brf_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic              state, state_next;
  logic [AW-1:0]     rd_idx, rd_next;
  logic [AW-1:0]     wr_idx, wr_next;
  logic [LW-1:0]     lvl, lvl_next;
  logic [AW-1:0]     rng_addr, rng_addr_next;
  logic [LW-1:0]     rng_left, rng_left_next;
  logic [LW-1:0]     rng_lvl, rng_lvl_next;

  logic              pend;
  logic [STAT_W-1:0] pend_status;
  logic [LW-1:0]     pend_level;
  logic              pend_last;
  logic              pend_mem;

  logic              issue;
  logic [STAT_W-1:0] iss_status;
  logic [LW-1:0]     iss_level;
  logic              iss_last;
  logic              iss_mem;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  logic              out_load;
  logic              slot_free;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  lvl_c;
  logic [LW-1:0]     lvl_sub;

  assign out_load  = pend && (!out_valid || !out_stall);
  assign slot_free = !pend || out_load;
  assign cmd_take  = (state == ST_IDLE) && cmd_valid && slot_free;
  assign full      = (lvl == LW'(DEPTH));
  assign empty     = (lvl == '0);
  assign lvl_c     = CNT_W'(lvl);
  assign lvl_sub   = LW'(lvl_c - cmd.count);

  always_comb begin
    state_next    = state;
    rd_next       = rd_idx;
    wr_next       = wr_idx;
    lvl_next      = lvl;
    rng_addr_next = rng_addr;
    rng_left_next = rng_left;
    rng_lvl_next  = rng_lvl;
    issue         = 1'b0;
    iss_status    = ST_OK;
    iss_level     = lvl;
    iss_last      = 1'b1;
    iss_mem       = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = rd_idx;
    if (cmd_take) begin
      issue = 1'b1;
      unique case (cmd.op)
        OP_PUSH: begin
          if (full) begin
            iss_status = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            wr_next   = wrap_inc(wr_idx);
            lvl_next  = lvl + LW'(1);
            iss_level = lvl + LW'(1);
          end
        end
        OP_PUSH_OW: begin
          mem_we  = 1'b1;
          wr_next = wrap_inc(wr_idx);
          if (full) begin
            rd_next = wrap_inc(rd_idx);
          end else begin
            lvl_next  = lvl + LW'(1);
            iss_level = lvl + LW'(1);
          end
        end
        OP_POP, OP_PEEK: begin
          if (empty) begin
            iss_status = ST_EMPTY;
          end else begin
            mem_re  = 1'b1;
            iss_mem = 1'b1;
            if (cmd.op == OP_POP) begin
              iss_level = lvl - LW'(1);
              if (lvl == LW'(1)) begin
                rd_next  = '0;
                wr_next  = '0;
                lvl_next = '0;
              end else begin
                rd_next  = wrap_inc(rd_idx);
                lvl_next = lvl - LW'(1);
              end
            end
          end
        end
        OP_DROP: begin
          if (!cmd.cnt_zero) begin
            if (cmd.count >= lvl_c) begin
              rd_next   = '0;
              wr_next   = '0;
              lvl_next  = '0;
              iss_level = '0;
            end else begin
              rd_next   = wrap_add(rd_idx, cmd.count[AW-1:0]);
              lvl_next  = lvl_sub;
              iss_level = lvl_sub;
            end
          end
        end
        OP_PEEK_RANGE, OP_POP_RANGE: begin
          if (empty) begin
            iss_status = ST_EMPTY;
          end else if (cmd.count > lvl_c) begin
            iss_status = ST_SHORT;
          end else if (!cmd.cnt_zero) begin
            mem_re   = 1'b1;
            iss_mem  = 1'b1;
            iss_last = (cmd.count == CNT_W'(1));
            if (cmd.op == OP_POP_RANGE) begin
              iss_level = lvl_sub;
              if (cmd.count == lvl_c) begin
                rd_next  = '0;
                wr_next  = '0;
                lvl_next = '0;
              end else begin
                rd_next  = wrap_add(rd_idx, cmd.count[AW-1:0]);
                lvl_next = lvl_sub;
              end
            end
            if (cmd.count != CNT_W'(1)) begin
              state_next    = ST_RANGE;
              rng_addr_next = wrap_inc(rd_idx);
              rng_left_next = LW'(cmd.count - CNT_W'(1));
              rng_lvl_next  = (cmd.op == OP_POP_RANGE) ? lvl_sub : lvl;
            end
          end
        end
        default: begin
          iss_status = ST_OK;
        end
      endcase
    end else if (state == ST_RANGE && slot_free) begin
      issue         = 1'b1;
      mem_re        = 1'b1;
      mem_raddr     = rng_addr;
      iss_mem       = 1'b1;
      iss_level     = rng_lvl;
      iss_last      = (rng_left == LW'(1));
      rng_addr_next = wrap_inc(rng_addr);
      rng_left_next = rng_left - LW'(1);
      if (rng_left == LW'(1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= cmd.data;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_idx    <= '0;
      wr_idx    <= '0;
      lvl       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_next;
      wr_idx <= wr_next;
      lvl    <= lvl_next;
      if (issue) begin
        pend <= 1'b1;
      end else if (out_load) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rng_addr <= rng_addr_next;
    rng_left <= rng_left_next;
    rng_lvl  <= rng_lvl_next;
    if (issue) begin
      pend_status <= iss_status;
      pend_level  <= iss_level;
      pend_last   <= iss_last;
      pend_mem    <= iss_mem;
    end
    if (out_load) begin
      status   <= pend_status;
      data_out <= pend_mem ? rd_q : '0;
      level    <= CNT_W'(pend_level);
      last     <= pend_last;
    end
  end

endmodule
`default_nettype wire

>>> hdl/byte_ring_fifo.sv
// top level of the byte ring fifo: front decoder and queue, back end, checks
//
// Input channel (in_valid/in_stall) takes one operation per transfer: mode,
// data_in and item_count. Output channel (out_valid/out_stall) gives result
// transfers: status, data_out, level and last. Every operation gives at
// least one result; a successful range read gives item_count results, oldest
// byte first, with last set on the final one.
// A result travels from the command queue through the back end staging
// register into the result register.
// Throughput: one single-byte operation per cycle while out_stall is low; a
// range read holds the back end for item_count reads, one byte per cycle.
// The figure is set by the single read port of the byte store and the one
// result staging register ahead of the output register.
// A two-entry command queue parts the sides: input keeps flowing until it
// fills, then in_stall rises. While out_stall is high the result holds and
// the back end halts once its staging register is full.
// Reset empties the queue and clears both ring pointers and the fill level;
// stored bytes are not cleared and are only read after being written.
`default_nettype none
module byte_ring_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [brf_pkg::MODE_W-1:0]  mode,
  input  wire logic [brf_pkg::DATA_W-1:0]  data_in,
  input  wire logic [brf_pkg::CNT_W-1:0]   item_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [brf_pkg::STAT_W-1:0]       status,
  output logic [brf_pkg::DATA_W-1:0]       data_out,
  output logic [brf_pkg::CNT_W-1:0]        level,
  output logic                             last
);
  import brf_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  brf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .data_in    (data_in),
    .item_count (item_count),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  brf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out),
    .level     (level),
    .last      (last)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= CNT_W'(DEPTH)))
    else $error("result level above depth");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (last && data_out == '0))
    else $error("error result not a single zero-data transfer");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (level == '0))
    else $error("empty status with nonzero level");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule
`default_nettype wire
